@@ rtl/b64d_pkg.sv @@
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and constants for the base64url stream decoder
// Holds the result record, the output queue sizing and the character decode.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int unsigned MaxResults = 3;
  localparam int unsigned FifoDepth  = 8;
  localparam int unsigned FifoAw     = $clog2(FifoDepth);

  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5A;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerZ = 8'h7A;
  localparam logic [7:0] CharDigit0 = 8'h30;
  localparam logic [7:0] CharDigit9 = 8'h39;
  localparam logic [7:0] CharDash   = 8'h2D;
  localparam logic [7:0] CharUnder  = 8'h5F;

  localparam logic [5:0] SymLowerBase = 6'd26;
  localparam logic [5:0] SymDigitBase = 6'd52;
  localparam logic [5:0] SymDash      = 6'd62;
  localparam logic [5:0] SymUnder     = 6'd63;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic       end_of_message;
  } b64d_result_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] value;
  } b64d_sym_t;

  function automatic b64d_sym_t sym_decode(input logic [7:0] c);
    b64d_sym_t s;
    s.ok    = 1'b1;
    s.value = '0;
    if (c inside {[CharUpperA:CharUpperZ]}) begin
      s.value = 6'(c - CharUpperA);
    end else if (c inside {[CharLowerA:CharLowerZ]}) begin
      s.value = 6'(c - CharLowerA) + SymLowerBase;
    end else if (c inside {[CharDigit0:CharDigit9]}) begin
      s.value = 6'(c - CharDigit0) + SymDigitBase;
    end else if (c == CharDash) begin
      s.value = SymDash;
    end else if (c == CharUnder) begin
      s.value = SymUnder;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

@@ rtl/b64d_if.sv @@
// ----------------------------------------------------------------------------
// b64d_if: request channels of the base64url stream decoder
// One interface for incoming characters and one for decoded results.
// ----------------------------------------------------------------------------
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       end_of_input;

  modport source (output valid, output symbol, output end_of_input, input ready);
  modport sink   (input valid, input symbol, input end_of_input, output ready);
endinterface

interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last_of_run;
  logic       end_of_message;

  modport source (output valid, output data_byte, output byte_valid,
                  output last_of_run, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input byte_valid,
                  input last_of_run, input end_of_message, output ready);
endinterface

@@ rtl/base64url_stream_decoder.sv @@
// The results of an accepted request are registered into the output queue and offered from its head.
// Throughput: one character per cycle; results leave one per cycle from an
// eight-entry queue, and a character is taken while three entries are free.
// A group of four characters yields three results, so bursts only stall input
// when the result side is held off.
// Reset: synchronous, active low; clears the group state and empties the queue.
// ----------------------------------------------------------------------------
// base64url_stream_decoder: URL-safe base64 character stream to bytes
// Decodes one character per request and queues up to three result records for each.
// ----------------------------------------------------------------------------
module base64url_stream_decoder (
  input  logic       clk,
  input  logic       rst_n,
  b64d_in_if.sink    in_bus,
  b64d_out_if.source out_bus
);
  import b64d_pkg::*;

  localparam logic [FifoAw:0] AcceptLimit = (FifoAw + 1)'(FifoDepth - MaxResults);

  logic [1:0]   group_count_r, group_count_nxt;
  logic [17:0]  held_symbols_r, held_symbols_nxt;
  logic         decode_stopped_r, decode_stopped_nxt;

  b64d_result_t fifo_r [FifoDepth];
  logic [FifoAw-1:0] wr_ptr_r, rd_ptr_r;
  logic [FifoAw:0]   count_r, count_nxt;

  logic         in_acc, out_acc;
  b64d_sym_t    sym;
  logic         emit_full, flush_en, last;
  logic [1:0]   gc_mid;
  logic [17:0]  held_mid;
  logic [23:0]  word;
  logic [7:0]   bytes [MaxResults];
  logic [1:0]   n_bytes, n_res;
  b64d_result_t ent [MaxResults];

  assign in_bus.ready = (count_r <= AcceptLimit);
  assign in_acc  = in_bus.valid && in_bus.ready;
  assign out_acc = out_bus.valid && out_bus.ready;

  always_comb begin
    sym       = sym_decode(in_bus.symbol);
    last      = in_bus.end_of_input;
    word      = {held_symbols_r, sym.value};
    emit_full = !decode_stopped_r && sym.ok && (group_count_r == 2'd3);
    flush_en  = (!decode_stopped_r && !sym.ok) || (last && !emit_full);

    gc_mid   = group_count_r;
    held_mid = held_symbols_r;
    if (!decode_stopped_r && sym.ok) begin
      if (emit_full) begin
        gc_mid   = 2'd0;
        held_mid = '0;
      end else begin
        gc_mid   = group_count_r + 2'd1;
        held_mid = {held_symbols_r[11:0], sym.value};
      end
    end

    bytes[0] = '0;
    bytes[1] = '0;
    bytes[2] = '0;
    n_bytes  = 2'd0;
    if (emit_full) begin
      bytes[0] = word[23:16];
      bytes[1] = word[15:8];
      bytes[2] = word[7:0];
      n_bytes  = 2'd3;
    end else if (flush_en) begin
      case (gc_mid)
        2'd2: begin
          bytes[0] = held_mid[11:4];
          n_bytes  = 2'd1;
        end
        2'd3: begin
          bytes[0] = held_mid[17:10];
          bytes[1] = held_mid[9:2];
          n_bytes  = 2'd2;
        end
        default: n_bytes = 2'd0;
      endcase
    end

    n_res = n_bytes;
    for (int k = 0; k < MaxResults; k++) begin
      ent[k].data_byte      = bytes[k];
      ent[k].byte_valid     = 1'b1;
      ent[k].last_of_run    = (2'(k) == n_bytes - 2'd1);
      ent[k].end_of_message = last && (2'(k) == n_bytes - 2'd1);
    end
    if (last && (n_bytes == 2'd0)) begin
      ent[0] = '{data_byte: 8'h00, byte_valid: 1'b0, last_of_run: 1'b1,
                 end_of_message: 1'b1};
      n_res  = 2'd1;
    end

    if (last) begin
      group_count_nxt    = 2'd0;
      held_symbols_nxt   = '0;
      decode_stopped_nxt = 1'b0;
    end else if (!decode_stopped_r && !sym.ok) begin
      group_count_nxt    = 2'd0;
      held_symbols_nxt   = '0;
      decode_stopped_nxt = 1'b1;
    end else begin
      group_count_nxt    = gc_mid;
      held_symbols_nxt   = held_mid;
      decode_stopped_nxt = decode_stopped_r;
    end

    count_nxt = count_r + (in_acc ? (FifoAw + 1)'(n_res) : '0)
                - (FifoAw + 1)'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_count_r    <= '0;
      held_symbols_r   <= '0;
      decode_stopped_r <= 1'b0;
      wr_ptr_r         <= '0;
      rd_ptr_r         <= '0;
      count_r          <= '0;
    end else begin
      if (in_acc) begin
        group_count_r    <= group_count_nxt;
        held_symbols_r   <= held_symbols_nxt;
        decode_stopped_r <= decode_stopped_nxt;
        wr_ptr_r         <= wr_ptr_r + FifoAw'(n_res);
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MaxResults; k++) begin
      if (in_acc && (2'(k) < n_res)) begin
        fifo_r[wr_ptr_r + FifoAw'(k)] <= ent[k];
      end
    end
  end

  assign out_bus.valid          = (count_r != '0);
  assign out_bus.data_byte      = fifo_r[rd_ptr_r].data_byte;
  assign out_bus.byte_valid     = fifo_r[rd_ptr_r].byte_valid;
  assign out_bus.last_of_run    = fifo_r[rd_ptr_r].last_of_run;
  assign out_bus.end_of_message = fifo_r[rd_ptr_r].end_of_message;

endmodule

@@ rtl/b64d_checker.sv @@
// ----------------------------------------------------------------------------
// b64d_checker: port-level checks for the base64url stream decoder
// Watches the result channel and the framing flags of each result.
// ----------------------------------------------------------------------------
module b64d_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_data_byte,
  input logic       out_byte_valid,
  input logic       out_last_of_run,
  input logic       out_end_of_message
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result request dropped while stalled.");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data_byte) && $stable(out_byte_valid))
    else $error("Result payload changed while stalled.");

  a_eom_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_message |-> out_last_of_run)
    else $error("End of message without end of run.");

  a_empty_is_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_end_of_message && out_data_byte == 8'h00)
    else $error("Byte-less result that is not an end marker.");

endmodule

bind base64url_stream_decoder b64d_checker u_b64d_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_bus.valid),
  .out_ready          (out_bus.ready),
  .out_data_byte      (out_bus.data_byte),
  .out_byte_valid     (out_bus.byte_valid),
  .out_last_of_run    (out_bus.last_of_run),
  .out_end_of_message (out_bus.end_of_message)
);

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the base64url stream decoder
// Sends character requests with random gaps and checks every decoded result
// against a byte predictor. The result side stalls at random and holds off
// for a long stretch once, so that the output queue fills and blocks input.
// ----------------------------------------------------------------------------
module tb_top;
  import b64d_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned ItemTarget  = 210;

  localparam logic [7:0] AsciiUpA  = 8'h41;
  localparam logic [7:0] AsciiUpZ  = 8'h5A;
  localparam logic [7:0] AsciiLowA = 8'h61;
  localparam logic [7:0] AsciiLowZ = 8'h7A;
  localparam logic [7:0] AsciiZero = 8'h30;
  localparam logic [7:0] AsciiNine = 8'h39;
  localparam logic [7:0] AsciiDash = 8'h2D;
  localparam logic [7:0] AsciiUndr = 8'h5F;
  localparam logic [7:0] AsciiPad  = 8'h3D;

  logic clk;
  logic rst_n;

  b64d_in_if  in_bus ();
  b64d_out_if out_bus ();

  base64url_stream_decoder dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  // Predictor state.
  logic [1:0]  group_len;
  logic [17:0] group_bits;
  logic        decode_halted;

  b64d_result_t pending_results[$];
  int unsigned  mismatch_count;
  int unsigned  decoded_items;
  int unsigned  cycle_count;
  bit           src_quiet;
  bit           sink_quiet;
  int unsigned  hold_request;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("base64url_stream_decoder verification failed");
    $finish;
  end

  function automatic int sextet_of(input logic [7:0] ch);
    if (ch >= AsciiUpA && ch <= AsciiUpZ) return int'(ch - AsciiUpA);
    if (ch >= AsciiLowA && ch <= AsciiLowZ) return int'(ch - AsciiLowA) + 26;
    if (ch >= AsciiZero && ch <= AsciiNine) return int'(ch - AsciiZero) + 52;
    if (ch == AsciiDash) return 62;
    if (ch == AsciiUndr) return 63;
    return -1;
  endfunction

  function automatic logic [7:0] random_b64_char();
    logic [7:0] s;
    s = 8'($urandom_range(0, 63));
    if (s < 8'd26) return AsciiUpA + s;
    if (s < 8'd52) return AsciiLowA + (s - 8'd26);
    if (s < 8'd62) return AsciiZero + (s - 8'd52);
    if (s == 8'd62) return AsciiDash;
    return AsciiUndr;
  endfunction

  // A partial group of k sextets yields k-1 bytes.
  task automatic flush_group(ref logic [7:0] bytes[$]);
    if (group_len == 2'd2) begin
      bytes.push_back(group_bits[11:4]);
    end else if (group_len == 2'd3) begin
      bytes.push_back(group_bits[17:10]);
      bytes.push_back(group_bits[9:2]);
    end
    group_len  = 2'd0;
    group_bits = '0;
  endtask

  task automatic predict_bytes(input logic [7:0] ch, input logic last);
    logic [7:0]   bytes[$];
    logic [23:0]  word;
    b64d_result_t res;
    int           v;
    decoded_items++;
    if (!decode_halted) begin
      v = sextet_of(ch);
      if (v >= 0) begin
        if (group_len == 2'd3) begin
          word = {group_bits, 6'(v)};
          bytes.push_back(word[23:16]);
          bytes.push_back(word[15:8]);
          bytes.push_back(word[7:0]);
          group_len  = 2'd0;
          group_bits = '0;
        end else begin
          group_bits = {group_bits[11:0], 6'(v)};
          group_len  = group_len + 2'd1;
        end
      end else begin
        flush_group(bytes);
        decode_halted = 1'b1;
      end
    end
    if (last) begin
      flush_group(bytes);
      decode_halted = 1'b0;
    end
    foreach (bytes[k]) begin
      res.data_byte      = bytes[k];
      res.byte_valid     = 1'b1;
      res.last_of_run    = (k == bytes.size() - 1);
      res.end_of_message = last && (k == bytes.size() - 1);
      pending_results.push_back(res);
    end
    if (last && bytes.size() == 0) begin
      res.data_byte      = 8'h00;
      res.byte_valid     = 1'b0;
      res.last_of_run    = 1'b1;
      res.end_of_message = 1'b1;
      pending_results.push_back(res);
    end
  endtask

  task automatic send_char(input logic [7:0] ch, input logic last);
    int gap;
    gap = src_quiet ? 0 : $urandom_range(0, 15);
    repeat (gap) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk);
    in_bus.valid        <= 1'b1;
    in_bus.symbol       <= ch;
    in_bus.end_of_input <= last;
    do @(posedge clk); while (!in_bus.ready);
    predict_bytes(ch, last);
  endtask

  task automatic send_string(input string s, input logic last_at_end);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], last_at_end && (i == s.len() - 1));
    end
  endtask

  task automatic test_full_groups();
    send_string("AZaz09-_", 1'b1);
    send_string("__", 1'b1);
  endtask

  task automatic test_terminators();
    send_string("Q=x", 1'b0);
    send_char(8'hFF, 1'b1);
    send_string("ABC", 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'h80, 1'b1);
    send_char(AsciiUpA, 1'b1);
    send_char(8'h7B, 1'b1);
    send_string("AB", 1'b0);
    send_char(AsciiPad, 1'b1);
  endtask

  task automatic test_backpressure();
    src_quiet    = 1'b1;
    sink_quiet   = 1'b0;
    hold_request = 150;
    for (int i = 0; i < 40; i++) begin
      send_char(random_b64_char(), i == 39);
    end
    src_quiet = 1'b0;
  endtask

  task automatic test_random_messages();
    int         len;
    int         kind;
    int         stop_at;
    logic [7:0] ch;
    while (decoded_items < ItemTarget) begin
      len        = $urandom_range(1, 12);
      kind       = $urandom_range(0, 9);
      src_quiet  = ($urandom_range(0, 3) == 0);
      sink_quiet = ($urandom_range(0, 3) == 0);
      stop_at    = (kind < 5) ? len : $urandom_range(0, len - 1);
      for (int i = 0; i < len; i++) begin
        if (kind >= 8) begin
          ch = 8'($urandom_range(0, 255));
        end else if (i < stop_at) begin
          ch = random_b64_char();
        end else if (i == stop_at) begin
          ch = $urandom_range(0, 1) ? AsciiPad : 8'($urandom_range(0, 255));
        end else begin
          ch = 8'($urandom_range(0, 255));
        end
        send_char(ch, i == len - 1);
      end
    end
    src_quiet  = 1'b0;
    sink_quiet = 1'b0;
  endtask

  initial begin : result_checker
    b64d_result_t want;
    int           stall;
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_request > 0) begin
        stall        = hold_request;
        hold_request = 0;
      end else begin
        stall = sink_quiet ? 0 : $urandom_range(0, 15);
      end
      repeat (stall) begin
        @(negedge clk);
        out_bus.ready <= 1'b0;
      end
      @(negedge clk);
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, got byte %02h valid %b last %b end %b",
                 $time, out_bus.data_byte, out_bus.byte_valid, out_bus.last_of_run,
                 out_bus.end_of_message);
      end else begin
        want = pending_results.pop_front();
        if (out_bus.data_byte !== want.data_byte) begin
          mismatch_count++;
          $display("%0t: data_byte expected %02h, got %02h",
                   $time, want.data_byte, out_bus.data_byte);
        end
        if (out_bus.byte_valid !== want.byte_valid) begin
          mismatch_count++;
          $display("%0t: byte_valid expected %b, got %b",
                   $time, want.byte_valid, out_bus.byte_valid);
        end
        if (out_bus.last_of_run !== want.last_of_run) begin
          mismatch_count++;
          $display("%0t: last_of_run expected %b, got %b",
                   $time, want.last_of_run, out_bus.last_of_run);
        end
        if (out_bus.end_of_message !== want.end_of_message) begin
          mismatch_count++;
          $display("%0t: end_of_message expected %b, got %b",
                   $time, want.end_of_message, out_bus.end_of_message);
        end
      end
    end
  end

  initial begin : stimulus
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.symbol       = 8'h00;
    in_bus.end_of_input = 1'b0;
    group_len           = 2'd0;
    group_bits          = '0;
    decode_halted       = 1'b0;
    mismatch_count      = 0;
    decoded_items       = 0;
    cycle_count         = 0;
    src_quiet           = 1'b0;
    sink_quiet          = 1'b0;
    hold_request        = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_full_groups();
    test_terminators();
    test_backpressure();
    test_random_messages();

    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("base64url_stream_decoder verification clean");
    end else begin
      $display("base64url_stream_decoder verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/b64d_pkg.sv
rtl/b64d_if.sv
rtl/base64url_stream_decoder.sv
rtl/b64d_checker.sv
sim/tb_top.sv
